// File: hw/rtl/frsu_pkg.sv
package frsu_pkg;

	// Sizes of the sorted store and of the fields.
	localparam int MAX_AGENTS  = 32;
	localparam int FIT_W       = 16;
	localparam int IDX_W       = $clog2(MAX_AGENTS);
	localparam int CNT_W       = $clog2(MAX_AGENTS + 1);
	localparam int CFG_W       = 6;
	localparam int KEY_W       = FIT_W + 1;
	localparam int MIN_PARENTS = 4;
	localparam int RANK_W      = 5;

	// One stored agent: its fitness and its arrival number.
	typedef struct packed {
		logic signed [FIT_W-1:0] fitness;
		logic [IDX_W-1:0]        agent;
	} entry_t;

	// Per-cycle command to every cell of the chain.
	typedef struct packed {
		logic ins;
		logic shift;
	} cell_ctrl_t;

	// One result item as held in the output register.
	typedef struct packed {
		logic [RANK_W-1:0]       rank;
		logic [RANK_W-1:0]       agent_id;
		logic signed [FIT_W-1:0] agent_fitness;
		logic                    in_parent_pool;
		logic [RANK_W-1:0]       split_rank;
		logic                    all_equal;
		logic                    last;
	} out_item_t;

endpackage

// File: hw/rtl/frsu_if.sv
// Input channel: one fitness value per transfer.
interface frsu_in_if;
	import frsu_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [FIT_W-1:0] fitness;
	modport source (output valid, output fitness, input ready);
	modport sink (input valid, input fitness, output ready);
endinterface

// Output channel: one ranked agent per transfer.
interface frsu_out_if;
	import frsu_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [RANK_W-1:0]       rank;
	logic [RANK_W-1:0]       agent_id;
	logic signed [FIT_W-1:0] agent_fitness;
	logic                    in_parent_pool;
	logic [RANK_W-1:0]       split_rank;
	logic                    all_equal;
	logic                    last;
	modport source (output valid, output rank, output agent_id, output agent_fitness,
		output in_parent_pool, output split_rank, output all_equal, output last,
		input ready);
	modport sink (input valid, input rank, input agent_id, input agent_fitness,
		input in_parent_pool, input split_rank, input all_equal, input last,
		output ready);
endinterface

// File: hw/rtl/frsu_cell.sv
module frsu_cell (
	input  logic                clk,
	input  frsu_pkg::cell_ctrl_t ctrl,
	input  frsu_pkg::entry_t    ins_e,
	input  logic                occ,
	input  frsu_pkg::entry_t    left_e,
	input  logic                left_gt,
	input  frsu_pkg::entry_t    right_e,
	output frsu_pkg::entry_t    cur,
	output logic                gt
);
	import frsu_pkg::*;

	entry_t ent_q;

	// An empty cell counts as larger than any value, so it takes part in the shift.
	// Equal values stay in place, which keeps arrival order among ties.
	assign gt  = !occ || (ent_q.fitness > ins_e.fitness);
	assign cur = ent_q;

	// Insert: a larger cell takes its left neighbor, or the new value if it is the
	// first larger cell. Shift: every cell takes its right neighbor.
	always_ff @(posedge clk) begin
		if (ctrl.ins && gt) begin
			ent_q <= left_gt ? left_e : ins_e;
		end else if (ctrl.shift) begin
			ent_q <= right_e;
		end
	end

endmodule

// File: hw/rtl/frsu_chain.sv
module frsu_chain (
	input  logic                          clk,
	input  frsu_pkg::cell_ctrl_t          ctrl,
	input  frsu_pkg::entry_t              ins_e,
	input  logic [frsu_pkg::CNT_W-1:0]    count,
	input  logic [frsu_pkg::IDX_W-1:0]    rd_addr,
	output frsu_pkg::entry_t              rd_data,
	output frsu_pkg::entry_t              head
);
	import frsu_pkg::*;

	entry_t ent   [MAX_AGENTS];
	logic   gt    [MAX_AGENTS];
	entry_t left  [MAX_AGENTS];
	logic   lgt   [MAX_AGENTS];
	entry_t right [MAX_AGENTS];
	logic   occ   [MAX_AGENTS];

	// Row of cells; each one sees its two neighbors.
	for (genvar i = 0; i < MAX_AGENTS; i++) begin : g_cell
		assign occ[i] = (CNT_W'(i) < count);
		if (i == 0) begin : g_first
			assign left[i] = ins_e;
			assign lgt[i]  = 1'b0;
		end else begin : g_inner
			assign left[i] = ent[i-1];
			assign lgt[i]  = gt[i-1];
		end
		if (i == MAX_AGENTS - 1) begin : g_end
			assign right[i] = ent[i];
		end else begin : g_mid
			assign right[i] = ent[i+1];
		end
		frsu_cell u_cell (
			.clk     (clk),
			.ctrl    (ctrl),
			.ins_e   (ins_e),
			.occ     (occ[i]),
			.left_e  (left[i]),
			.left_gt (lgt[i]),
			.right_e (right[i]),
			.cur     (ent[i]),
			.gt      (gt[i])
		);
	end

	// Single probe port for the search, and the lowest entry for emission.
	assign rd_data = ent[rd_addr];
	assign head    = ent[0];

endmodule

// File: hw/rtl/fitness_rank_and_split_unit.sv
// Fitness rank and split unit.
// Load: the samples channel takes one signed fitness per transfer, one per cycle,
// until agent_count values (clamped to 4..32) have arrived; the agent id is the
// arrival number. Each value is inserted into a chain of 32 sorting cells on the
// cycle it arrives, equal values keeping arrival order.
// Rank: the start state forms the midpoint key from the lowest and highest value;
// if they are equal it goes straight to emit, else a binary search probes one cell
// per cycle, up to 6 probes, ending on an exact match or in a closing step.
// Emit: the results channel gives every agent in ascending rank, one per cycle
// while the receiver is ready, with split rank, parent-pool mark and all-equal
// flag; last marks the final one. A stall holds the output register and the chain.
// No samples are taken from the last sample transfer until the last result transfer.
// Reset: agent_count returns to 32, the load is empty and no result is pending.
// Writing agent_count (cfg_we, cfg_wdata) is taken only while loading and discards any partial load.
module fitness_rank_and_split_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	frsu_in_if.sink                    samples,
	frsu_out_if.source                 results,
	input  logic                       cfg_we,
	input  logic [frsu_pkg::CFG_W-1:0] cfg_wdata
);
	import frsu_pkg::*;

	localparam logic [1:0] ST_LOAD   = 2'd0;
	localparam logic [1:0] ST_START  = 2'd1;
	localparam logic [1:0] ST_SEARCH = 2'd2;
	localparam logic [1:0] ST_EMIT   = 2'd3;

	logic [1:0]             state_q;
	logic [CFG_W-1:0]       cfg_count_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       n_c;
	logic signed [KEY_W-1:0] key_q;
	logic                   eq_q;
	logic [CNT_W-1:0]       left_q;
	logic [CNT_W-1:0]       rp1_q;
	logic [IDX_W-1:0]       mid_q;
	logic [IDX_W-1:0]       split_q;
	logic [CNT_W-1:0]       emit_q;
	logic                   out_valid_q;
	out_item_t              res_q;

	cell_ctrl_t             ctrl;
	entry_t                 ins_e;
	entry_t                 rd_data;
	entry_t                 head;
	logic [IDX_W-1:0]       rd_addr;
	logic                   in_xfer;
	logic                   out_xfer;
	logic                   emit_load;
	logic [CNT_W:0]         mid_sum;
	logic [IDX_W-1:0]       mid_c;
	logic signed [KEY_W-1:0] lo_k;
	logic signed [KEY_W-1:0] hi_k;
	logic signed [KEY_W-1:0] sum_c;
	logic signed [KEY_W-1:0] rnd_c;
	logic signed [KEY_W-1:0] key_c;
	logic signed [KEY_W-1:0] probe_k;

	// Clamp the split so that at least MIN_PARENTS agents lie at or above it.
	function automatic logic [IDX_W-1:0] clamp_split(input logic [IDX_W-1:0] s,
		input logic [CNT_W-1:0] n);
		logic [CNT_W-1:0] above;
		above = n - CNT_W'(s);
		if (above < CNT_W'(MIN_PARENTS)) begin
			return IDX_W'(n - CNT_W'(MIN_PARENTS));
		end
		return s;
	endfunction

	// Effective agent count.
	always_comb begin
		if (cfg_count_q < CFG_W'(MIN_PARENTS)) begin
			n_c = CNT_W'(MIN_PARENTS);
		end else if (CNT_W'(cfg_count_q) > CNT_W'(MAX_AGENTS)) begin
			n_c = CNT_W'(MAX_AGENTS);
		end else begin
			n_c = CNT_W'(cfg_count_q);
		end
	end

	// Handshakes.
	assign samples.ready = (state_q == ST_LOAD);
	assign in_xfer       = samples.valid && samples.ready;
	assign out_xfer      = out_valid_q && results.ready;
	assign emit_load     = (state_q == ST_EMIT) && (emit_q < n_c)
		&& (!out_valid_q || results.ready);

	// Chain commands and the new entry.
	assign ctrl.ins      = in_xfer;
	assign ctrl.shift    = emit_load;
	assign ins_e.fitness = samples.fitness;
	assign ins_e.agent   = count_q[IDX_W-1:0];

	// Probe address: next midpoint while searching, top entry in the start cycle.
	assign mid_sum = (CNT_W+1)'(left_q) + (CNT_W+1)'(rp1_q) - (CNT_W+1)'(1);
	assign mid_c   = mid_sum[IDX_W:1];
	assign rd_addr = (state_q == ST_START) ? IDX_W'(n_c - CNT_W'(1)) : mid_c;

	frsu_chain u_chain (
		.clk     (clk),
		.ctrl    (ctrl),
		.ins_e   (ins_e),
		.count   (count_q),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.head    (head)
	);

	// Midpoint key, rounded toward zero.
	assign lo_k    = {head.fitness[FIT_W-1], head.fitness};
	assign hi_k    = {rd_data.fitness[FIT_W-1], rd_data.fitness};
	assign sum_c   = lo_k + hi_k;
	assign rnd_c   = sum_c + {{(KEY_W-1){1'b0}}, sum_c[KEY_W-1]};
	assign key_c   = rnd_c >>> 1;
	assign probe_k = {rd_data.fitness[FIT_W-1], rd_data.fitness};

	// Sequencer: load, key, search, emit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cfg_count_q <= CFG_W'(MAX_AGENTS);
			count_q     <= '0;
			eq_q        <= 1'b0;
			left_q      <= '0;
			rp1_q       <= '0;
			mid_q       <= '0;
			split_q     <= '0;
			emit_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (cfg_we) begin
						cfg_count_q <= cfg_wdata;
						count_q     <= '0;
					end else if (in_xfer) begin
						count_q <= count_q + CNT_W'(1);
						if (count_q + CNT_W'(1) == n_c) begin
							state_q <= ST_START;
						end
					end
				end
				ST_START: begin
					eq_q   <= (lo_k == hi_k);
					left_q <= '0;
					rp1_q  <= n_c;
					mid_q  <= '0;
					emit_q <= '0;
					if (lo_k == hi_k) begin
						split_q <= '0;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (left_q < rp1_q) begin
						mid_q <= mid_c;
						if (key_q < probe_k) begin
							rp1_q <= CNT_W'(mid_c);
						end else if (key_q > probe_k) begin
							left_q <= CNT_W'(mid_c) + CNT_W'(1);
						end else begin
							split_q <= clamp_split(mid_c, n_c);
							state_q <= ST_EMIT;
						end
					end else begin
						split_q <= clamp_split(mid_q, n_c);
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_load) begin
						out_valid_q <= 1'b1;
						emit_q      <= emit_q + CNT_W'(1);
					end else if (out_xfer) begin
						out_valid_q <= 1'b0;
					end
					if (out_xfer && res_q.last) begin
						count_q <= '0;
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Key register is written once per run.
	always_ff @(posedge clk) begin
		if (state_q == ST_START) begin
			key_q <= key_c;
		end
	end

	// Output register, filled from the lowest cell as the chain shifts down.
	always_ff @(posedge clk) begin
		if (emit_load) begin
			res_q.rank           <= emit_q[RANK_W-1:0];
			res_q.agent_id       <= RANK_W'(head.agent);
			res_q.agent_fitness  <= head.fitness;
			res_q.in_parent_pool <= !eq_q && (emit_q[IDX_W-1:0] >= split_q);
			res_q.split_rank     <= RANK_W'(split_q);
			res_q.all_equal      <= eq_q;
			res_q.last           <= (emit_q == n_c - CNT_W'(1));
		end
	end

	assign results.valid          = out_valid_q;
	assign results.rank           = res_q.rank;
	assign results.agent_id       = res_q.agent_id;
	assign results.agent_fitness  = res_q.agent_fitness;
	assign results.in_parent_pool = res_q.in_parent_pool;
	assign results.split_rank     = res_q.split_rank;
	assign results.all_equal      = res_q.all_equal;
	assign results.last           = res_q.last;

	// A result is only pending while emitting.
	a_valid_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (state_q == ST_EMIT))
		else $error("result pending outside emission");

	// The load never reaches the agent count while still loading.
	a_load_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> (count_q < n_c))
		else $error("load count overran agent count");

	// The split leaves at least the minimum parent pool.
	a_split_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_EMIT) && !eq_q) |-> (CNT_W'(split_q) + CNT_W'(MIN_PARENTS) <= n_c))
		else $error("split rank not clamped");

	// The last result transfer ends the run with an empty load.
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && res_q.last) |=> ((state_q == ST_LOAD) && (count_q == '0)))
		else $error("run did not return to loading");

	// No more results are produced than agents were loaded.
	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (emit_q <= n_c))
		else $error("emission index overran agent count");

endmodule
